FILE: rtl/lsf_pkg.sv
package lsf_pkg;

    localparam int MAC_W    = 48;
    localparam int PORT_W   = 5;
    localparam int STATUS_W = 2;

    // highest port number that can ever be flooded or forwarded to
    localparam logic [PORT_W-1:0] MAX_PORTS = 5'd16;

    localparam logic [STATUS_W-1:0] STATUS_UNICAST = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FLOOD   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NONE    = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_EMIT
    } state_t;

    // lookup word walking down the cell chain
    typedef struct packed {
        logic              valid;
        logic [MAC_W-1:0]  dst;
        logic [MAC_W-1:0]  src;
        logic [PORT_W-1:0] ingress;
        logic              dst_hit;
        logic [PORT_W-1:0] dst_port;
        logic              src_hit;
    } query_t;

endpackage

FILE: rtl/lsf_cell.sv
module lsf_cell
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       used,
    input  logic                       load,
    input  logic [lsf_pkg::MAC_W-1:0]  load_mac,
    input  logic [lsf_pkg::PORT_W-1:0] load_port,
    input  lsf_pkg::query_t            q_in,
    output lsf_pkg::query_t            q_out
);

    logic [lsf_pkg::MAC_W-1:0]  mac_reg;
    logic [lsf_pkg::MAC_W-1:0]  mac_next;
    logic [lsf_pkg::PORT_W-1:0] port_reg;
    logic [lsf_pkg::PORT_W-1:0] port_next;
    lsf_pkg::query_t            q_reg;
    lsf_pkg::query_t            q_next;
    logic                       dst_match;
    logic                       src_match;

    assign dst_match = used && q_in.valid && !q_in.dst_hit && (mac_reg == q_in.dst);
    assign src_match = used && q_in.valid && !q_in.src_hit && (mac_reg == q_in.src);

    always_comb
    begin
        q_next = q_in;
        // destination sees the port as it was before this frame's learning
        if (dst_match)
        begin
            q_next.dst_hit  = 1'b1;
            q_next.dst_port = port_reg;
        end
        if (src_match)
        begin
            q_next.src_hit = 1'b1;
        end

        mac_next  = mac_reg;
        port_next = port_reg;
        if (load)
        begin
            mac_next  = load_mac;
            port_next = load_port;
        end
        else if (src_match)
        begin
            port_next = q_in.ingress;
        end
    end

    always_ff @(posedge clk)
    begin
        mac_reg  <= mac_next;
        port_reg <= port_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q_out = q_reg;

endmodule

FILE: rtl/learning_switch_forwarding.sv
// Learning bridge forwarding: each input word is a frame header (destination MAC,
// source MAC, ingress port). The MAC table is a row of TABLE_DEPTH cells, one entry
// per cell; a lookup word walks the row one cell per clock, matching destination and
// source on its way and refreshing the port of a known source in place. When the walk
// ends the source is learned and the result words follow: one for a known destination,
// otherwise one flooded copy for each port from 1 to port_count (capped at 16) except
// the ingress port, or a single no-port word when no port is left; output stalls hold
// them back. The next header is accepted as soon as the last result word sits in
// the output register. A new source is appended to the table; once the table is
// full it is not stored and learn_dropped is set on every result word of that frame.
module learning_switch_forwarding #(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [4:0]   cfg_wdata,       // port_count
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,    // dest_mac, src_mac, ingress_port, zero pad
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata,    // egress_port, status, learn_dropped
    output logic         m_axis_tlast
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int MW    = lsf_pkg::MAC_W;
    localparam int PW    = lsf_pkg::PORT_W;

    lsf_pkg::state_t state_reg;
    lsf_pkg::state_t state_next;

    logic [CNT_W-1:0] entry_count_reg;
    logic [CNT_W-1:0] entry_count_next;
    logic [PW-1:0]    port_count_reg;

    logic             hit_reg;
    logic             hit_next;
    logic [PW-1:0]    dport_reg;
    logic [PW-1:0]    dport_next;
    logic [PW-1:0]    ingress_reg;
    logic [PW-1:0]    ingress_next;
    logic             dropped_reg;
    logic             dropped_next;
    logic [PW:0]      cur_reg;
    logic [PW:0]      cur_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_data_reg;
    logic [7:0]       out_data_next;
    logic             out_last_reg;
    logic             out_last_next;

    logic             load_en;
    logic [PW-1:0]    ports;
    logic [PW:0]      cur_inc;
    logic [PW:0]      cur_adv;
    logic             flood_last;
    logic             flood_none;
    logic             accept;

    lsf_pkg::query_t  chain [TABLE_DEPTH+1];
    lsf_pkg::query_t  tail;

    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        chain[0].valid    = accept;
        chain[0].dst      = s_axis_tdata[MW-1:0];
        chain[0].src      = s_axis_tdata[2*MW-1:MW];
        chain[0].ingress  = s_axis_tdata[2*MW+PW-1:2*MW];
        chain[0].dst_hit  = 1'b0;
        chain[0].dst_port = '0;
        chain[0].src_hit  = 1'b0;
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            lsf_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .used      (entry_count_reg > CNT_W'(g)),
                .load      (load_en && (entry_count_reg[IDX_W-1:0] == IDX_W'(g))),
                .load_mac  (tail.src),
                .load_port (tail.ingress),
                .q_in      (chain[g]),
                .q_out     (chain[g+1])
            );
        end
    endgenerate

    assign tail = chain[TABLE_DEPTH];

    assign ports      = (port_count_reg > lsf_pkg::MAX_PORTS) ? lsf_pkg::MAX_PORTS
                                                              : port_count_reg;
    assign cur_inc    = cur_reg + (PW+1)'(1);
    assign cur_adv    = (cur_inc == {1'b0, ingress_reg}) ? cur_reg + (PW+1)'(2) : cur_inc;
    assign flood_last = cur_adv > {1'b0, ports};
    assign flood_none = cur_reg > {1'b0, ports};

    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        hit_next         = hit_reg;
        dport_next       = dport_reg;
        ingress_next     = ingress_reg;
        dropped_next     = dropped_reg;
        cur_next         = cur_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        out_last_next    = out_last_reg;
        load_en          = 1'b0;
        s_axis_tready    = (state_reg == lsf_pkg::S_IDLE);

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            lsf_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = lsf_pkg::S_SEARCH;
                end
            end
            lsf_pkg::S_SEARCH:
            begin
                if (tail.valid)
                begin
                    hit_next     = tail.dst_hit;
                    dport_next   = tail.dst_port;
                    ingress_next = tail.ingress;
                    cur_next     = (tail.ingress == PW'(1)) ? (PW+1)'(2) : (PW+1)'(1);
                    dropped_next = 1'b0;
                    if (!tail.src_hit)
                    begin
                        if (entry_count_reg < CNT_W'(TABLE_DEPTH))
                        begin
                            load_en          = 1'b1;
                            entry_count_next = entry_count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            dropped_next = 1'b1;
                        end
                    end
                    state_next = lsf_pkg::S_EMIT;
                end
            end
            lsf_pkg::S_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next    = 1'b1;
                    out_data_next[7]  = dropped_reg;
                    if (hit_reg)
                    begin
                        if (dport_reg >= PW'(1) && dport_reg <= ports)
                        begin
                            out_data_next[4:0] = dport_reg;
                            out_data_next[6:5] = lsf_pkg::STATUS_UNICAST;
                        end
                        else
                        begin
                            out_data_next[4:0] = '0;
                            out_data_next[6:5] = lsf_pkg::STATUS_INVALID;
                        end
                        out_last_next = 1'b1;
                        state_next    = lsf_pkg::S_IDLE;
                    end
                    else if (flood_none)
                    begin
                        out_data_next[4:0] = '0;
                        out_data_next[6:5] = lsf_pkg::STATUS_NONE;
                        out_last_next      = 1'b1;
                        state_next         = lsf_pkg::S_IDLE;
                    end
                    else
                    begin
                        out_data_next[4:0] = cur_reg[PW-1:0];
                        out_data_next[6:5] = lsf_pkg::STATUS_FLOOD;
                        out_last_next      = flood_last;
                        cur_next           = cur_adv;
                        if (flood_last)
                        begin
                            state_next = lsf_pkg::S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = lsf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= lsf_pkg::S_IDLE;
            entry_count_reg <= '0;
            port_count_reg  <= 5'd16;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_we)
            begin
                port_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg      <= hit_next;
        dport_reg    <= dport_next;
        ingress_reg  <= ingress_next;
        dropped_reg  <= dropped_next;
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int TABLE_DEPTH = 64;
    localparam int POOL_SIZE   = 48;
    localparam int SETTLE      = 100;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 5;
    localparam int MW          = lsf_pkg::MAC_W;
    localparam int PW          = lsf_pkg::PORT_W;
    localparam int SW          = lsf_pkg::STATUS_W;

    localparam int PHASE_ITEMS [PHASES] = '{45, 55, 55, 55, 55};
    localparam int PHASE_PORTS [PHASES] = '{16, 5, 31, 2, 12};
    localparam int PHASE_SEND  [PHASES] = '{0, 49, 0, 25, 0};
    localparam int PHASE_RECV  [PHASES] = '{0, 0, 49, 25, 0};

    localparam logic [MW-1:0] MAC_ZERO = 48'h0000_0000_0000;
    localparam logic [MW-1:0] MAC_ONES = 48'hffff_ffff_ffff;
    localparam logic [MW-1:0] MAC_A    = 48'h0200_5e00_0001;
    localparam logic [MW-1:0] MAC_C    = 48'h0a0b_0c0d_0e0f;
    localparam logic [MW-1:0] MAC_D    = 48'h8000_0000_0001;
    localparam logic [MW-1:0] MAC_E    = 48'h02aa_55aa_55aa;
    localparam logic [MW-1:0] MAC_F    = 48'h00c0_ffee_0042;
    localparam logic [MW-1:0] MAC_G    = 48'h3c3c_3c3c_3c3c;
    localparam logic [MW-1:0] MAC_H    = 48'hc3c3_c3c3_c3c3;
    // never used as a source, so they always miss
    localparam logic [MW-1:0] MAC_U1   = 48'h7fff_ffff_fffe;
    localparam logic [MW-1:0] MAC_U2   = 48'h5555_5555_5555;
    localparam logic [MW-1:0] MAC_U3   = 48'haaaa_aaaa_aaaa;

    typedef struct {
        logic [PW-1:0] egress;
        logic [SW-1:0] status;
        logic          dropped;
        logic          last;
    } fwd_word_t;

    typedef enum logic {ROW_FRAME, ROW_PORTS} row_kind_t;

    typedef struct {
        row_kind_t     kind;
        logic [MW-1:0] dst;
        logic [MW-1:0] src;
        logic [PW-1:0] ingress;
        logic [PW-1:0] port_count;
        bit            fixed;
        logic [PW-1:0] egress;
        logic [SW-1:0] status;
    } dir_row_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         cfg_we;
    logic [4:0]   cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;
    logic         m_axis_tlast;

    logic [MW-1:0] tbl_mac  [TABLE_DEPTH];
    logic [PW-1:0] tbl_port [TABLE_DEPTH];
    int            tbl_used;
    logic [PW-1:0] port_limit;
    logic [MW-1:0] mac_pool [POOL_SIZE];

    fwd_word_t pending_q[$];
    fwd_word_t head;
    int        errors;
    int        cycles;
    int        snd_pct;
    int        rcv_pct;

    learning_switch_forwarding uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    function automatic bit mac_lookup(input logic [MW-1:0] mac, output int idx);
        idx = 0;
        for (int i = 0; i < tbl_used; i++)
        begin
            if (tbl_mac[i] == mac)
            begin
                idx = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // forwarding decision for one header, then learn its source
    function automatic void forward_frame(input logic [MW-1:0] dst,
                                          input logic [MW-1:0] src,
                                          input logic [PW-1:0] ing,
                                          output fwd_word_t words[$]);
        logic [PW-1:0] ports;
        int            idx;
        logic          dropped;
        fwd_word_t     w;
        words.delete();
        ports = (port_limit > lsf_pkg::MAX_PORTS) ? lsf_pkg::MAX_PORTS : port_limit;
        dropped = 1'b0;
        w.dropped = 1'b0;
        w.last = 1'b0;
        if (mac_lookup(dst, idx))
        begin
            if (tbl_port[idx] >= 1 && tbl_port[idx] <= ports)
            begin
                w.egress = tbl_port[idx];
                w.status = lsf_pkg::STATUS_UNICAST;
            end
            else
            begin
                w.egress = '0;
                w.status = lsf_pkg::STATUS_INVALID;
            end
            words.push_back(w);
        end
        else
        begin
            for (int p = 1; p <= ports; p++)
            begin
                if (p != ing)
                begin
                    w.egress = p[PW-1:0];
                    w.status = lsf_pkg::STATUS_FLOOD;
                    words.push_back(w);
                end
            end
            if (words.size() == 0)
            begin
                w.egress = '0;
                w.status = lsf_pkg::STATUS_NONE;
                words.push_back(w);
            end
        end
        if (mac_lookup(src, idx))
            tbl_port[idx] = ing;
        else if (tbl_used < TABLE_DEPTH)
        begin
            tbl_mac[tbl_used] = src;
            tbl_port[tbl_used] = ing;
            tbl_used++;
        end
        else
            dropped = 1'b1;
        foreach (words[k])
            words[k].dropped = dropped;
        words[words.size()-1].last = 1'b1;
    endfunction

    function automatic dir_row_t frame_row(
        input logic [MW-1:0] dst,
        input logic [MW-1:0] src,
        input logic [PW-1:0] ing,
        input bit            fixed = 1'b0,
        input logic [PW-1:0] egress = '0,
        input logic [SW-1:0] status = lsf_pkg::STATUS_UNICAST);
        dir_row_t r;
        r.kind = ROW_FRAME;
        r.dst = dst;
        r.src = src;
        r.ingress = ing;
        r.port_count = '0;
        r.fixed = fixed;
        r.egress = egress;
        r.status = status;
        return r;
    endfunction

    function automatic dir_row_t ports_row(input logic [PW-1:0] value);
        dir_row_t r;
        r = frame_row(MAC_ZERO, MAC_ZERO, '0);
        r.kind = ROW_PORTS;
        r.port_count = value;
        return r;
    endfunction

    task automatic send_frame(input logic [MW-1:0] dst, input logic [MW-1:0] src,
                              input logic [PW-1:0] ing, input bit fixed,
                              input logic [PW-1:0] egress,
                              input logic [SW-1:0] status);
        fwd_word_t words[$];
        fwd_word_t w;
        while (snd_pct > 0 && $urandom_range(99) < snd_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, ing, src, dst};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        forward_frame(dst, src, ing, words);
        if (fixed)
        begin
            w.egress = egress;
            w.status = status;
            w.dropped = 1'b0;
            w.last = 1'b1;
            pending_q.push_back(w);
        end
        else
        begin
            foreach (words[k])
                pending_q.push_back(words[k]);
        end
        @(negedge clk);
    endtask

    // hold the sender until every result word is out, then let the block settle
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_port_count(input logic [PW-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        port_limit = value;
    endtask

    task automatic check_field(input string name, input logic [7:0] expected,
                               input logic [7:0] actual);
        if (expected !== actual)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                     expected, actual);
        end
    endtask

    always @(negedge clk)
        m_axis_tready <= (rcv_pct == 0) || ($urandom_range(99) >= rcv_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual tdata %h tlast %b",
                         $time, m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                head = pending_q.pop_front();
                check_field("egress_port", 8'(head.egress), 8'(m_axis_tdata[4:0]));
                check_field("status", 8'(head.status), 8'(m_axis_tdata[6:5]));
                check_field("learn_dropped", 8'(head.dropped), 8'(m_axis_tdata[7]));
                check_field("last", 8'(head.last), 8'(m_axis_tlast));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        dir_row_t      rows[$];
        logic [MW-1:0] dst;
        logic [MW-1:0] src;
        logic [PW-1:0] ing;
        int            r;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        errors        = 0;
        cycles        = 0;
        snd_pct       = 0;
        rcv_pct       = 0;
        tbl_used      = 0;
        port_limit    = 5'd16;
        foreach (mac_pool[i])
            mac_pool[i] = MW'({$urandom, $urandom});
        mac_pool[0] = MAC_ZERO;
        mac_pool[1] = MAC_ONES;

        rows.push_back(frame_row(MAC_U1, MAC_A, 5'd1));
        rows.push_back(frame_row(MAC_A, MAC_ONES, 5'd16, 1'b1, 5'd1, lsf_pkg::STATUS_UNICAST));
        rows.push_back(frame_row(MAC_ONES, MAC_ZERO, 5'd3, 1'b1, 5'd16, lsf_pkg::STATUS_UNICAST));
        rows.push_back(frame_row(MAC_ZERO, MAC_C, 5'd0, 1'b1, 5'd3, lsf_pkg::STATUS_UNICAST));
        rows.push_back(frame_row(MAC_C, MAC_D, 5'd31, 1'b1, 5'd0, lsf_pkg::STATUS_INVALID));
        rows.push_back(frame_row(MAC_D, MAC_A, 5'd5, 1'b1, 5'd0, lsf_pkg::STATUS_INVALID));
        rows.push_back(frame_row(MAC_A, MAC_A, 5'd7, 1'b1, 5'd5, lsf_pkg::STATUS_UNICAST));
        // hit on the port the frame came in on: forward there anyway
        rows.push_back(frame_row(MAC_A, MAC_E, 5'd7, 1'b1, 5'd7, lsf_pkg::STATUS_UNICAST));
        // out of range ingress: flood to all sixteen
        rows.push_back(frame_row(MAC_U2, MAC_G, 5'd20));
        rows.push_back(frame_row(MAC_U3, MAC_H, 5'd16));
        rows.push_back(ports_row(5'd1));
        rows.push_back(frame_row(MAC_U1, MAC_F, 5'd1, 1'b1, 5'd0, lsf_pkg::STATUS_NONE));
        rows.push_back(frame_row(MAC_U2, MAC_F, 5'd2, 1'b1, 5'd1, lsf_pkg::STATUS_FLOOD));
        rows.push_back(frame_row(MAC_A, MAC_E, 5'd1, 1'b1, 5'd0, lsf_pkg::STATUS_INVALID));
        rows.push_back(ports_row(5'd0));
        rows.push_back(frame_row(MAC_U3, MAC_C, 5'd1, 1'b1, 5'd0, lsf_pkg::STATUS_NONE));
        rows.push_back(frame_row(MAC_ONES, MAC_C, 5'd4, 1'b1, 5'd0, lsf_pkg::STATUS_INVALID));
        // port counts above the port range saturate
        rows.push_back(ports_row(5'd31));
        rows.push_back(frame_row(MAC_ONES, MAC_D, 5'd2, 1'b1, 5'd16, lsf_pkg::STATUS_UNICAST));
        rows.push_back(frame_row(MAC_U1, MAC_D, 5'd16));
        rows.push_back(ports_row(5'd17));
        rows.push_back(frame_row(MAC_E, MAC_A, 5'd3, 1'b1, 5'd1, lsf_pkg::STATUS_UNICAST));
        rows.push_back(frame_row(MAC_G, MAC_A, 5'd3, 1'b1, 5'd0, lsf_pkg::STATUS_INVALID));
        rows.push_back(ports_row(5'd16));

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_PORTS)
                set_port_count(rows[i].port_count);
            else
                send_frame(rows[i].dst, rows[i].src, rows[i].ingress, rows[i].fixed,
                           rows[i].egress, rows[i].status);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_port_count(PHASE_PORTS[ph][PW-1:0]);
            snd_pct = PHASE_SEND[ph];
            rcv_pct = PHASE_RECV[ph];
            for (int n = 0; n < PHASE_ITEMS[ph]; n++)
            begin
                // mostly known addresses so lookups hit and the table fills up
                r = $urandom_range(99);
                if (r < 65)
                    dst = mac_pool[$urandom_range(POOL_SIZE-1)];
                else if (r < 75)
                    dst = (r < 70) ? MAC_ZERO : MAC_ONES;
                else
                    dst = MW'({$urandom, $urandom});
                if ($urandom_range(99) < 88)
                    src = mac_pool[$urandom_range(POOL_SIZE-1)];
                else
                    src = MW'({$urandom, $urandom});
                if ($urandom_range(99) < 85)
                    ing = PW'($urandom_range(16, 1));
                else
                    ing = PW'($urandom_range(31, 0));
                send_frame(dst, src, ing, 1'b0, '0, lsf_pkg::STATUS_UNICAST);
            end
        end

        drain();
        if (errors == 0 && pending_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
